// ===== src/tcbe_pkg.sv =====
// shared types and constants for the character-cell text buffer
package tcbe_pkg;

	localparam int REQ_W      = 2;
	localparam int KEY_W      = 4;
	localparam int CHAR_W     = 16;
	localparam int REP_W      = 16;
	localparam int RCOL_W     = 7;
	localparam int RROW_W     = 6;
	localparam int COL_OUT_W  = 7;
	localparam int ROW_OUT_W  = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int COLS_CFG_W = 8;
	localparam int ROWS_CFG_W = 7;

	localparam logic [CHAR_W-1:0] SPACE_CODE   = 16'h0020;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 16'h0008;
	localparam logic [CHAR_W-1:0] CH_TAB       = 16'h0009;
	localparam logic [CHAR_W-1:0] CH_LF        = 16'h000A;
	localparam logic [CHAR_W-1:0] CH_CR        = 16'h000D;
	localparam logic [CHAR_W-1:0] CH_ESC       = 16'h001B;

	typedef enum logic [REQ_W-1:0] {
		REQ_NAV  = 2'd0,
		REQ_CHAR = 2'd1,
		REQ_READ = 2'd2
	} req_type_t;

	typedef enum logic [KEY_W-1:0] {
		KEY_HOME   = 4'd0,
		KEY_END    = 4'd1,
		KEY_PGUP   = 4'd2,
		KEY_PGDN   = 4'd3,
		KEY_LEFT   = 4'd4,
		KEY_RIGHT  = 4'd5,
		KEY_UP     = 4'd6,
		KEY_DOWN   = 4'd7,
		KEY_DELETE = 4'd8
	} key_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COLS = 1'b0,
		CFG_ROWS = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FILL,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_DEL_END,
		ST_RD_WAIT,
		ST_DONE
	} tcbe_state_t;

	typedef struct packed {
		logic [COL_OUT_W-1:0] cursor_col;
		logic [ROW_OUT_W-1:0] cursor_row;
		logic [CHAR_W-1:0]    cell_value;
	} tcbe_result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tcbe_stat_t;

endpackage

// ===== src/tcbe_ifs.sv =====
// request and result channel interfaces
interface tcbe_req_if
	import tcbe_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [KEY_W-1:0]  key_code;
	logic [CHAR_W-1:0] char_code;
	logic [REP_W-1:0]  repeat_count;
	logic [RCOL_W-1:0] read_col;
	logic [RROW_W-1:0] read_row;

	modport source (output valid, req_type, key_code, char_code, repeat_count,
		read_col, read_row, input ready);
	modport sink (input valid, req_type, key_code, char_code, repeat_count,
		read_col, read_row, output ready);
endinterface

interface tcbe_rsp_if
	import tcbe_pkg::*;
	();
	logic                 valid;
	logic                 ready;
	logic [COL_OUT_W-1:0] cursor_col;
	logic [ROW_OUT_W-1:0] cursor_row;
	logic [CHAR_W-1:0]    cell_value;

	modport source (output valid, cursor_col, cursor_row, cell_value, input ready);
	modport sink (input valid, cursor_col, cursor_row, cell_value, output ready);
endinterface

// ===== src/tcbe_mem.sv =====
// cell store: one write port, one registered read port
module tcbe_mem
	import tcbe_pkg::*;
#(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] wcol,
	input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] wrow,
	input  logic [CHAR_W-1:0]             wdata,
	input  logic                          re,
	input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] rcol,
	input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] rrow,
	output logic [CHAR_W-1:0]             rdata
);
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CHAR_W-1:0] mem_q [DEPTH];
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [CHAR_W-1:0] rdata_q;

	// row-major address
	assign waddr = AW'(wrow) * AW'(MAX_COLS) + AW'(wcol);
	assign raddr = AW'(rrow) * AW'(MAX_COLS) + AW'(rcol);

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/tcbe_ctrl.sv =====
// request sequencer: cursor, size registers, row valid bits and cell edits
module tcbe_ctrl
	import tcbe_pkg::*;
#(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64,
	parameter int TAB_STOP = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tcbe_req_if.sink              req,
	output logic                  mem_we,
	output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] mem_wcol,
	output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] mem_wrow,
	output logic [CHAR_W-1:0]     mem_wdata,
	output logic                  mem_re,
	output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] mem_rcol,
	output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] mem_rrow,
	input  logic [CHAR_W-1:0]     mem_rdata,
	input  logic                  out_free,
	output tcbe_result_t          res,
	output tcbe_stat_t            stat
);
	localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COLS_RST = (MAX_COLS < 80) ? MAX_COLS : 80;
	localparam int ROWS_RST = (MAX_ROWS < 25) ? MAX_ROWS : 25;

	tcbe_state_t state_q, state_d;

	logic [CW-1:0]       col_q;
	logic [RW-1:0]       row_q;
	logic [CW:0]         cols_q;
	logic [RW:0]         rows_q;
	logic [MAX_ROWS-1:0] rowv_q;

	req_type_t         req_q;
	key_code_t         key_q;
	logic [CHAR_W-1:0] code_q;
	logic [REP_W-1:0]  reps_q;
	logic [RCOL_W-1:0] rcol_q;
	logic [RROW_W-1:0] rrow_q;
	logic [CW-1:0]     x_q;
	logic [CHAR_W-1:0] cell_q;

	logic [MAX_COLS-1:0] tab_hit;
	logic [CW:0]         col_p1;
	logic [RW:0]         row_p1;
	logic [CW:0]         x_p1;
	logic [CW:0]         x_p2;
	logic                col_last;
	logic                row_wrap;
	logic [RW-1:0]       row_next;
	logic [CW-1:0]       put_next_col;
	logic [CW-1:0]       cols_m1;
	logic [RW-1:0]       rows_m1;
	logic                rowv_cur;
	logic                tab_done;
	logic                rep_last;
	logic                reps_zero;
	logic                code_put;
	logic                put_ok;
	logic                rep_step;
	logic [CHAR_W-1:0]   put_data;
	logic [8:0]          rcol9;
	logic [CW+9:0]       cols_ext;
	logic [7:0]          rrow8;
	logic [RW+8:0]       rows_ext;
	logic [CW+RCOL_W-1:0] rcol_ext;
	logic [RW+RROW_W-1:0] rrow_ext;
	logic [CW-1:0]       rcol_idx;
	logic [RW-1:0]       rrow_idx;
	logic                rd_hit;
	logic [8:0]          cols_cv;
	logic [8:0]          cols_cl;
	logic [7:0]          rows_cv;
	logic [7:0]          rows_cl;
	logic [CW+COL_OUT_W-1:0] col_out_ext;
	logic [RW+ROW_OUT_W-1:0] row_out_ext;

	// columns that are tab stops, fixed at elaboration
	for (genvar i = 0; i < MAX_COLS; i++) begin : g_tab
		assign tab_hit[i] = ((i % TAB_STOP) == 0);
	end

	// cursor and sweep arithmetic
	assign col_p1       = {1'b0, col_q} + (CW+1)'(1);
	assign row_p1       = {1'b0, row_q} + (RW+1)'(1);
	assign x_p1         = {1'b0, x_q} + (CW+1)'(1);
	assign x_p2         = x_p1 + (CW+1)'(1);
	assign col_last     = !(col_p1 < cols_q);
	assign row_wrap     = !(row_p1 < rows_q);
	assign row_next     = row_wrap ? '0 : row_p1[RW-1:0];
	assign put_next_col = col_last ? '0 : col_p1[CW-1:0];
	assign cols_m1      = cols_q[CW-1:0] - CW'(1);
	assign rows_m1      = rows_q[RW-1:0] - RW'(1);
	assign rowv_cur     = rowv_q[row_q];
	assign tab_done     = tab_hit[put_next_col];
	assign rep_last     = (reps_q == REP_W'(1));
	assign reps_zero    = (reps_q == '0);

	// character classes
	always_comb begin
		unique case (code_q)
			CH_BACKSPACE, CH_LF, CH_CR, CH_ESC: code_put = 1'b0;
			default:                             code_put = 1'b1;
		endcase
	end
	assign put_data = (code_q == CH_TAB) ? SPACE_CODE : code_q;
	assign put_ok   = (req_q == REQ_CHAR) && !reps_zero && code_put && rowv_cur;

	// one repetition of a character request ends this cycle
	always_comb begin
		rep_step = 1'b0;
		if (state_q == ST_EXEC && req_q == REQ_CHAR && !reps_zero) begin
			if (code_q == CH_LF || code_q == CH_CR) begin
				rep_step = 1'b1;
			end else if (code_q == CH_BACKSPACE) begin
				rep_step = (col_q != '0) && !rowv_cur;
			end else if (code_put && rowv_cur) begin
				rep_step = (code_q != CH_TAB) || tab_done;
			end
		end else if (state_q == ST_DEL_END && req_q == REQ_CHAR) begin
			rep_step = 1'b1;
		end
	end

	// read request range check and cell index
	assign rcol9    = {2'b00, rcol_q};
	assign cols_ext = {9'd0, cols_q};
	assign rrow8    = {2'b00, rrow_q};
	assign rows_ext = {8'd0, rows_q};
	assign rcol_ext = {{CW{1'b0}}, rcol_q};
	assign rrow_ext = {{RW{1'b0}}, rrow_q};
	assign rcol_idx = rcol_ext[CW-1:0];
	assign rrow_idx = rrow_ext[RW-1:0];
	assign rd_hit   = (rcol9 < cols_ext[8:0]) && (rrow8 < rows_ext[7:0])
		&& rowv_q[rrow_idx];

	// size register clamping
	assign cols_cv = {1'b0, cfg_data[COLS_CFG_W-1:0]};
	assign cols_cl = (cols_cv == '0) ? 9'd1
		: ((cols_cv > 9'(MAX_COLS)) ? 9'(MAX_COLS) : cols_cv);
	assign rows_cv = {1'b0, cfg_data[ROWS_CFG_W-1:0]};
	assign rows_cl = (rows_cv == '0) ? 8'd1
		: ((rows_cv > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : rows_cv);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (req_q)
					REQ_NAV: begin
						if (key_q == KEY_DELETE && rowv_cur) begin
							state_d = (col_p1 < cols_q) ? ST_DEL_RD : ST_DEL_END;
						end else begin
							state_d = ST_DONE;
						end
					end
					REQ_CHAR: begin
						if (reps_zero || code_q == CH_ESC) begin
							state_d = ST_DONE;
						end else if (code_q == CH_BACKSPACE) begin
							if (col_q == '0) state_d = ST_DONE;
							else if (rowv_cur) state_d = ST_DEL_RD;
							else state_d = rep_last ? ST_DONE : ST_EXEC;
						end else if (code_q == CH_LF || code_q == CH_CR) begin
							state_d = rep_last ? ST_DONE : ST_EXEC;
						end else if (!rowv_cur) begin
							state_d = ST_FILL;
						end else if (rep_step && rep_last) begin
							state_d = ST_DONE;
						end else begin
							state_d = ST_EXEC;
						end
					end
					REQ_READ: state_d = rd_hit ? ST_RD_WAIT : ST_DONE;
					default:  state_d = ST_DONE;
				endcase
			end
			ST_FILL:    state_d = (x_p1 < cols_q) ? ST_FILL : ST_EXEC;
			ST_DEL_RD:  state_d = ST_DEL_WR;
			ST_DEL_WR:  state_d = (x_p2 < cols_q) ? ST_DEL_RD : ST_DEL_END;
			ST_DEL_END: state_d = (req_q == REQ_CHAR && !rep_last) ? ST_EXEC : ST_DONE;
			ST_RD_WAIT: state_d = ST_DONE;
			ST_DONE:    state_d = out_free ? ST_IDLE : ST_DONE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		mem_we    = 1'b0;
		mem_wcol  = col_q;
		mem_wrow  = row_q;
		mem_wdata = SPACE_CODE;
		mem_re    = 1'b0;
		mem_rcol  = x_p1[CW-1:0];
		mem_rrow  = row_q;
		unique case (state_q)
			ST_EXEC: begin
				if (put_ok) begin
					mem_we    = 1'b1;
					mem_wdata = put_data;
				end
				if (req_q == REQ_READ) begin
					mem_re   = rd_hit;
					mem_rcol = rcol_idx;
					mem_rrow = rrow_idx;
				end
			end
			ST_FILL: begin
				mem_we   = 1'b1;
				mem_wcol = x_q;
			end
			ST_DEL_RD: mem_re = 1'b1;
			ST_DEL_WR: begin
				mem_we    = 1'b1;
				mem_wcol  = x_q;
				mem_wdata = mem_rdata;
			end
			ST_DEL_END: begin
				mem_we   = 1'b1;
				mem_wcol = cols_m1;
			end
			default: ;
		endcase
		req.ready = (state_q == ST_IDLE);
		stat.busy = (state_q != ST_IDLE);
		stat.done = (state_q == ST_DONE) && out_free;
	end

	// result fields
	assign col_out_ext    = {{COL_OUT_W{1'b0}}, col_q};
	assign row_out_ext    = {{ROW_OUT_W{1'b0}}, row_q};
	assign res.cursor_col = col_out_ext[COL_OUT_W-1:0];
	assign res.cursor_row = row_out_ext[ROW_OUT_W-1:0];
	assign res.cell_value = cell_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// cursor, sizes and row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			cols_q <= (CW+1)'(COLS_RST);
			rows_q <= (RW+1)'(ROWS_RST);
			rowv_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				CFG_COLS: cols_q <= cols_cl[CW:0];
				CFG_ROWS: rows_q <= rows_cl[RW:0];
				default: ;
			endcase
			rowv_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else begin
			case (state_q)
				ST_EXEC: begin
					if (req_q == REQ_NAV) begin
						unique case (key_q)
							KEY_HOME:  col_q <= '0;
							KEY_END:   col_q <= cols_m1;
							KEY_PGUP:  row_q <= '0;
							KEY_PGDN:  row_q <= rows_m1;
							KEY_LEFT:  if (col_q != '0) col_q <= col_q - CW'(1);
							KEY_RIGHT: if (!col_last) col_q <= col_p1[CW-1:0];
							KEY_UP:    if (row_q != '0) row_q <= row_q - RW'(1);
							KEY_DOWN:  if (!row_wrap) row_q <= row_p1[RW-1:0];
							default: ;
						endcase
					end else if (req_q == REQ_CHAR && !reps_zero) begin
						if (code_q == CH_ESC) begin
							rowv_q <= '0;
							col_q  <= '0;
							row_q  <= '0;
						end else if (code_q == CH_BACKSPACE) begin
							if (col_q != '0) col_q <= col_q - CW'(1);
						end else if (code_q == CH_LF) begin
							row_q <= row_next;
						end else if (code_q == CH_CR) begin
							col_q <= '0;
							row_q <= row_next;
						end else if (rowv_cur) begin
							col_q <= put_next_col;
							if (col_last) row_q <= row_next;
						end
					end
				end
				ST_FILL: begin
					if (!(x_p1 < cols_q)) rowv_q[row_q] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// request fields, repeat counter, sweep index and read data
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					req_q  <= req_type_t'(req.req_type);
					key_q  <= key_code_t'(req.key_code);
					code_q <= req.char_code;
					reps_q <= req.repeat_count;
					rcol_q <= req.read_col;
					rrow_q <= req.read_row;
					cell_q <= '0;
				end
			end
			ST_EXEC: begin
				if (!rowv_cur) x_q <= '0;
				else if (req_q == REQ_CHAR && code_q == CH_BACKSPACE) x_q <= col_q - CW'(1);
				else x_q <= col_q;
				if (req_q == REQ_READ && !rd_hit) cell_q <= SPACE_CODE;
			end
			ST_FILL:    x_q <= x_p1[CW-1:0];
			ST_DEL_WR:  x_q <= x_p1[CW-1:0];
			ST_RD_WAIT: cell_q <= mem_rdata;
			default: ;
		endcase
		if (rep_step) reps_q <= reps_q - REP_W'(1);
	end

endmodule

// ===== src/text_cell_buffer_editor_top.sv =====
// top level of the character-cell text buffer with cursor
//
//  channel  dir  handshake          payload
//  req      in   req.valid/ready    req_type key_code char_code repeat_count read_col read_row
//  rsp      out  rsp.valid/ready    cursor_col cursor_row cell_value
//  cfg      in   cfg_we             cfg_idx cfg_data (0 column_count, 1 row_count)
//
// one request at a time; navigation, out-of-grid reads: EXEC then DONE; cell reads add RD_WAIT
// character requests run one repetition at a time, a tab one space per EXEC pass; the
// first write to a row after a clear first fills that row with spaces, one cell a cycle
// delete and backspace walk the rest of the row, a read then a write for each cell
// reset and size writes clear per-row valid bits at once, so there is no clearing pass
// a finished result waits in the output register while the next request is taken
module text_cell_buffer_editor_top
	import tcbe_pkg::*;
#(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64,
	parameter int TAB_STOP = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tcbe_req_if.sink              req,
	tcbe_rsp_if.source            rsp
);
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic              mem_we;
	logic [CW-1:0]     mem_wcol;
	logic [RW-1:0]     mem_wrow;
	logic [CHAR_W-1:0] mem_wdata;
	logic              mem_re;
	logic [CW-1:0]     mem_rcol;
	logic [RW-1:0]     mem_rrow;
	logic [CHAR_W-1:0] mem_rdata;
	logic              out_free;
	tcbe_result_t      res;
	tcbe_stat_t        stat;
	logic              rsp_valid_q;
	tcbe_result_t      rsp_q;

	tcbe_ctrl #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS),
		.TAB_STOP(TAB_STOP)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req),
		.mem_we   (mem_we),
		.mem_wcol (mem_wcol),
		.mem_wrow (mem_wrow),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_rcol (mem_rcol),
		.mem_rrow (mem_rrow),
		.mem_rdata(mem_rdata),
		.out_free (out_free),
		.res      (res),
		.stat     (stat)
	);

	tcbe_mem #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.wcol (mem_wcol),
		.wrow (mem_wrow),
		.wdata(mem_wdata),
		.re   (mem_re),
		.rcol (mem_rcol),
		.rrow (mem_rrow),
		.rdata(mem_rdata)
	);

	// output register is free when empty or being drained
	assign out_free = !rsp_valid_q || rsp.ready;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (stat.done) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cursor_col = rsp_q.cursor_col;
	assign rsp.cursor_row = rsp_q.cursor_row;
	assign rsp.cell_value = rsp_q.cell_value;

	// an accepted request keeps the sequencer busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> stat.busy)
		else $error("sequencer idle after request accept");

	// a result appears only after the sequencer finished one
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(stat.done))
		else $error("result valid without finished request");

	// a finished request always lands in the output register
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> rsp.valid)
		else $error("finished request not presented");

	// no new request while one is in progress
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !req.ready)
		else $error("request ready while busy");

endmodule
